// ===== hdl/frapq_pkg.sv =====
// Package: shared widths, request and status codes for the Fenwick range-add unit.
package frapq_pkg;

   localparam int DATA_W  = 64;
   localparam int INDEX_W = 11;
   localparam int COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [INDEX_W-1:0] index_type;

endpackage

// ===== hdl/frapq_ifs.sv =====
// Interfaces: request and response channels of the Fenwick range-add unit.
interface frapq_req_if
   import frapq_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      req_type;
   index_type first_index;
   index_type last_index;
   data_type  delta;

   modport source (output valid, output req_type, output first_index,
                   output last_index, output delta, input ready);
   modport sink   (input valid, input req_type, input first_index,
                   input last_index, input delta, output ready);
endinterface

interface frapq_rsp_if
   import frapq_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     status;
   data_type point_value;

   modport source (output valid, output status, output point_value, input ready);
   modport sink   (input valid, input status, input point_value, output ready);
endinterface

// ===== hdl/fenwick_range_add_point_query_unit.sv =====
// Top level: Fenwick tree over a difference array, range add and point query.
//
//  channel  | port           | direction | content
//  ---------+----------------+-----------+------------------------------------------
//  request  | req_ch         | in        | req_type, first_index, last_index, delta
//  response | rsp_ch         | out       | status, point_value
//  control  | csr_wr_*       | in        | elem_count write (11 bits)
//
// After reset the tree memory is cleared one word a cycle, with no request taken until the pass ends.
// A query walks down from first_index, one tree node per step; an add walks up from first_index
// and, when last_index is below the count, again from last_index + 1 with the delta subtracted.
// Every tree node takes one read and, for an add, one write on the single tree RAM.
// One request is in flight at a time; the next is taken once the result is in the output
// register, and a stalled response holds the sequencer only at its final step.
module fenwick_range_add_point_query_unit
   import frapq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   frapq_req_if.sink            req_ch,
   frapq_rsp_if.source          rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [COUNT_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH) + 2;
   localparam int CW = (PW > INDEX_W) ? PW : INDEX_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_QSTEP = 3'd2;
   localparam logic [2:0] S_ASTEP = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [PW-1:0]      second_ff, second_in;
   logic               two_ff, two_in;
   logic               sub_ff, sub_in;
   logic               status_ff, status_in;
   data_type           acc_ff, acc_in;
   data_type           addend_ff, addend_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   data_type           rsp_value_ff, rsp_value_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   data_type           wr_data, rd_data;
   data_type           sum, op_b;
   logic               op_sub;
   logic [PW-1:0]      pos_up, pos_down;

   logic [CW-1:0]      first_c, last_c, n_c, last_p1_c;
   logic               bad, accept;

   frapq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared unit: accumulate for queries, add or subtract the delta for updates
   assign op_b   = (state_ff == S_QSTEP) ? acc_ff : addend_ff;
   assign op_sub = (state_ff == S_ASTEP) && sub_ff;

   frapq_step #(.POS_W(PW)) u_step (
      .op_a     (rd_data),
      .op_b     (op_b),
      .sub      (op_sub),
      .pos      (idx_ff),
      .sum      (sum),
      .pos_up   (pos_up),
      .pos_down (pos_down)
   );

   // range checks against the active count, limited to DEPTH
   assign first_c   = CW'(req_ch.first_index);
   assign last_c    = CW'(req_ch.last_index);
   assign last_p1_c = last_c + CW'(1);
   assign n_c       = (CW'(count_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(count_ff);

   always_comb begin
      if (req_ch.req_type == REQ_QUERY) begin
         bad = (first_c == '0) || (first_c > n_c);
      end else begin
         bad = (first_c == '0) || (first_c > last_c) || (last_c > n_c);
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      second_in     = second_ff;
      two_in        = two_ff;
      sub_in        = sub_ff;
      status_in     = status_ff;
      acc_in        = acc_ff;
      addend_in     = addend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(idx_ff - PW'(1));
      wr_data       = sum;
      rd_en         = 1'b0;
      rd_addr       = AW'(idx_ff - PW'(1));

      // drop the response once it is transferred
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
            idx_in  = idx_ff + PW'(1);
            if (idx_ff == PW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               acc_in = '0;
               if (bad) begin
                  status_in = STATUS_RANGE;
                  state_in  = S_DONE;
               end else begin
                  status_in = STATUS_DONE;
                  idx_in    = PW'(first_c);
                  second_in = PW'(last_p1_c);
                  two_in    = (last_c < n_c);
                  sub_in    = 1'b0;
                  addend_in = req_ch.delta;
                  rd_en     = 1'b1;
                  rd_addr   = AW'(first_c - CW'(1));
                  state_in  = (req_ch.req_type == REQ_QUERY) ? S_QSTEP : S_ASTEP;
               end
            end
         end
         S_QSTEP: begin
            acc_in = sum;
            if (pos_down == '0) begin
               state_in = S_DONE;
            end else begin
               idx_in  = pos_down;
               rd_en   = 1'b1;
               rd_addr = AW'(pos_down - PW'(1));
            end
         end
         S_ASTEP: begin
            wr_en = 1'b1;
            if (pos_up <= PW'(DEPTH)) begin
               idx_in  = pos_up;
               rd_en   = 1'b1;
               rd_addr = AW'(pos_up - PW'(1));
            end else if (two_ff) begin
               two_in  = 1'b0;
               sub_in  = 1'b1;
               idx_in  = second_ff;
               rd_en   = 1'b1;
               rd_addr = AW'(second_ff - PW'(1));
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = acc_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the element count
   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         two_ff       <= 1'b0;
         sub_ff       <= 1'b0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         two_ff       <= two_in;
         sub_ff       <= sub_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      second_ff     <= second_in;
      status_ff     <= status_in;
      acc_ff        <= acc_in;
      addend_ff     <= addend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.point_value = rsp_value_ff;

   // no request is taken while the memory is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request taken during clearing pass");

   // a transferred request always leaves the idle state
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a transfer");

   // tree walks never visit position zero
   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_QSTEP) || (state_ff == S_ASTEP)) |-> (idx_ff != '0))
      else $error("tree walk reached position zero");

   // an error response carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_RANGE)) |-> (rsp_value_ff == '0))
      else $error("error response with nonzero value");

   // a pending response is never overwritten by a new result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready && (state_ff == S_DONE)) |=> (state_ff == S_DONE))
      else $error("response overwritten while stalled");

endmodule

// ===== hdl/frapq_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read.
module frapq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read; a same-cycle write to the read address is passed through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/frapq_step.sv =====
// Shared step unit: 64-bit add/subtract and the tree index moves up and down.
module frapq_step
   import frapq_pkg::*;
#(
   parameter int POS_W = 12
) (
   input  data_type           op_a,
   input  data_type           op_b,
   input  logic               sub,
   input  logic [POS_W-1:0]   pos,
   output data_type           sum,
   output logic [POS_W-1:0]   pos_up,
   output logic [POS_W-1:0]   pos_down
);

   logic [POS_W-1:0] low_bit;

   // lowest set bit of the position
   assign low_bit = pos & (~pos + POS_W'(1));

   // one adder, subtracting when asked
   assign sum = op_a + (op_b ^ {DATA_W{sub}}) + DATA_W'(sub);

   // parent for an update walk, predecessor for a prefix walk
   assign pos_up   = pos + low_bit;
   assign pos_down = pos & ~low_bit;

endmodule
